// ===== hw/rtl/rpwc_pkg.sv =====
// rpwc_pkg: shared types and constants of the rf pulse width code decoder
// no dependencies

package rpwc_pkg;

    localparam int FRAME_BYTES = 3;
    localparam int SLOT_W      = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int CODE_W      = 24;
    localparam int CNT_W       = 8;
    localparam int BITS_W      = 4;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [BITS_W-1:0] BITS_PER_BYTE = BITS_W'(8);
    localparam logic [CNT_W-1:0]  CNT_MAX       = '1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SHORT_LOW_MIN  = 3'd0,
        REG_SHORT_LOW_MAX  = 3'd1,
        REG_SYNC_LOW_MIN   = 3'd2,
        REG_SYNC_LOW_MAX   = 3'd3,
        REG_IDLE_GAP_TICKS = 3'd4
    } cfg_index_t;

    localparam logic [CFG_DATA_W-1:0] RST_SHORT_LOW_MIN  = 8'd10;
    localparam logic [CFG_DATA_W-1:0] RST_SHORT_LOW_MAX  = 8'd30;
    localparam logic [CFG_DATA_W-1:0] RST_SYNC_LOW_MIN   = 8'd120;
    localparam logic [CFG_DATA_W-1:0] RST_SYNC_LOW_MAX   = 8'd250;
    localparam logic [CFG_DATA_W-1:0] RST_IDLE_GAP_TICKS = 8'd250;

    typedef struct packed {
        logic [CNT_W-1:0] short_low_min;
        logic [CNT_W-1:0] short_low_max;
        logic [CNT_W-1:0] sync_low_min;
        logic [CNT_W-1:0] sync_low_max;
        logic [CNT_W-1:0] idle_gap_ticks;
    } cfg_t;

    typedef struct packed {
        logic             decode;
        logic [CNT_W-1:0] run_len;
    } pulse_evt_t;

    typedef struct packed {
        logic              emit;
        logic [CODE_W-1:0] code;
    } frame_evt_t;

endpackage

// ===== hw/rtl/rpwc_cfg_regs.sv =====
// rpwc_cfg_regs: configuration register file with write-only port
// depends on rpwc_pkg

module rpwc_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [rpwc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [rpwc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output rpwc_pkg::cfg_t                  cfg
);
    import rpwc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_SHORT_LOW_MIN:  cfg_next.short_low_min  = cfg_wr_data;
                REG_SHORT_LOW_MAX:  cfg_next.short_low_max  = cfg_wr_data;
                REG_SYNC_LOW_MIN:   cfg_next.sync_low_min   = cfg_wr_data;
                REG_SYNC_LOW_MAX:   cfg_next.sync_low_max   = cfg_wr_data;
                REG_IDLE_GAP_TICKS: cfg_next.idle_gap_ticks = cfg_wr_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_low_min  <= RST_SHORT_LOW_MIN;
            cfg_reg.short_low_max  <= RST_SHORT_LOW_MAX;
            cfg_reg.sync_low_min   <= RST_SYNC_LOW_MIN;
            cfg_reg.sync_low_max   <= RST_SYNC_LOW_MAX;
            cfg_reg.idle_gap_ticks <= RST_IDLE_GAP_TICKS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/rpwc_pulse_timer.sv =====
// rpwc_pulse_timer: low/high run counters and post-frame hold-off
// depends on rpwc_pkg

module rpwc_pulse_timer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic                line_level,
    input  logic                set_hold,
    input  rpwc_pkg::cfg_t      cfg,
    output rpwc_pkg::pulse_evt_t evt
);
    import rpwc_pkg::*;

    logic [CNT_W-1:0] low_cnt_reg, low_cnt_next;
    logic [CNT_W-1:0] high_cnt_reg, high_cnt_next;
    logic             low_seen_reg, low_seen_next;
    logic             hold_reg, hold_next;

    logic             gap;
    logic             hold_mid;
    logic [CNT_W-1:0] high_mid;

    always_comb begin
        gap      = ({1'b0, high_cnt_reg} + (CNT_W+1)'(1)) > {1'b0, cfg.idle_gap_ticks};
        hold_mid = gap ? 1'b0 : hold_reg;
        high_mid = gap ? '0 : high_cnt_reg + CNT_W'(1);

        evt.decode  = step && line_level && low_seen_reg && !hold_mid;
        evt.run_len = low_cnt_reg;

        low_cnt_next  = low_cnt_reg;
        high_cnt_next = high_cnt_reg;
        low_seen_next = low_seen_reg;
        hold_next     = hold_reg;

        if (step) begin
            if (!line_level) begin
                if (low_cnt_reg != CNT_MAX) begin
                    low_cnt_next = low_cnt_reg + CNT_W'(1);
                end
                low_seen_next = 1'b1;
                high_cnt_next = '0;
            end else begin
                high_cnt_next = high_mid;
                hold_next     = hold_mid;
                if (evt.decode) begin
                    high_cnt_next = '0;
                    low_seen_next = 1'b0;
                    low_cnt_next  = '0;
                end
                if (set_hold) begin
                    hold_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_cnt_reg  <= '0;
            high_cnt_reg <= '0;
            low_seen_reg <= 1'b0;
            hold_reg     <= 1'b0;
        end else begin
            low_cnt_reg  <= low_cnt_next;
            high_cnt_reg <= high_cnt_next;
            low_seen_reg <= low_seen_next;
            hold_reg     <= hold_next;
        end
    end

endmodule

// ===== hw/rtl/rpwc_frame_builder.sv =====
// rpwc_frame_builder: bit shifting, byte and frame assembly, repeat check
// depends on rpwc_pkg

module rpwc_frame_builder (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rpwc_pkg::pulse_evt_t pulse,
    input  rpwc_pkg::cfg_t       cfg,
    output rpwc_pkg::frame_evt_t evt
);
    import rpwc_pkg::*;

    typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

    logic              open_reg, open_next;
    logic [BITS_W-1:0] bits_reg, bits_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [7:0]        shift_reg, shift_next;
    frame_t            cur_reg, cur_next;
    frame_t            prev_reg, prev_next;

    logic              is_zero;
    logic              is_sync;
    logic [BITS_W-1:0] bits_dec;
    logic [7:0]        shift_new;
    logic [SLOT_W-1:0] slot_use;
    logic [SLOT_W:0]   slot_inc;
    logic [CODE_W-1:0] code;

    always_comb begin
        is_zero   = (pulse.run_len > cfg.short_low_min) && (pulse.run_len < cfg.short_low_max);
        is_sync   = (pulse.run_len > cfg.sync_low_min) && (pulse.run_len < cfg.sync_low_max);
        bits_dec  = bits_reg - BITS_W'(1);
        shift_new = {shift_reg[6:0], ~is_zero};
        slot_use  = ({1'b0, slot_reg} >= (SLOT_W+1)'(FRAME_BYTES)) ? '0 : slot_reg;
        slot_inc  = {1'b0, slot_use} + (SLOT_W+1)'(1);

        open_next  = open_reg;
        bits_next  = bits_reg;
        slot_next  = slot_reg;
        shift_next = shift_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        evt.emit   = 1'b0;

        if (pulse.decode) begin
            if (open_reg) begin
                if (bits_dec == '0) begin
                    bits_next           = BITS_PER_BYTE;
                    shift_next          = '0;
                    prev_next[slot_use] = cur_reg[slot_use];
                    cur_next[slot_use]  = shift_new;
                    if (slot_inc >= (SLOT_W+1)'(FRAME_BYTES)) begin
                        slot_next = '0;
                        open_next = 1'b0;
                        evt.emit  = (prev_next == cur_next);
                    end else begin
                        slot_next = slot_inc[SLOT_W-1:0];
                    end
                end else begin
                    bits_next  = bits_dec;
                    shift_next = shift_new;
                end
            end
            if (is_sync) begin
                open_next = 1'b1;
                bits_next = BITS_PER_BYTE;
            end
        end

        // first received byte ends up in the top bits
        code = '0;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            code = {code[CODE_W-9:0], cur_next[i]};
        end
        evt.code = code;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg  <= 1'b0;
            bits_reg  <= '0;
            slot_reg  <= '0;
            shift_reg <= '0;
            cur_reg   <= '0;
            prev_reg  <= '0;
        end else begin
            open_reg  <= open_next;
            bits_reg  <= bits_next;
            slot_reg  <= slot_next;
            shift_reg <= shift_next;
            cur_reg   <= cur_next;
            prev_reg  <= prev_next;
        end
    end

endmodule

// ===== hw/rtl/rf_pulse_width_code_decoder.sv =====
// rf_pulse_width_code_decoder: top level, input beat register, decode, result register
// depends on rpwc_pkg, rpwc_cfg_regs, rpwc_pulse_timer, rpwc_frame_builder
// a frame-completing input beat is held in the input beat register, then its code is captured in the result register
// throughput: one input beat per cycle while m_tready is high
// decode state advances once per input beat, when the beat leaves the input beat register
// reset: aresetn synchronous active low, clears all run and frame state, loads default limits

module rf_pulse_width_code_decoder (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,      // [0] line_level
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rpwc_pkg::CODE_W-1:0]     m_tdata,      // [23:0] code_word
    input  logic                            cfg_wr_en,
    input  logic [rpwc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [rpwc_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import rpwc_pkg::*;

    cfg_t       cfg;
    pulse_evt_t pulse;
    frame_evt_t frame;

    logic              in_valid_reg, in_valid_next;
    logic              line_reg, line_next;
    logic              out_valid_reg, out_valid_next;
    logic [CODE_W-1:0] code_reg, code_next;

    logic advance;
    logic step;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;

    rpwc_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    rpwc_pulse_timer u_timer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .line_level (line_reg),
        .set_hold   (frame.emit),
        .cfg        (cfg),
        .evt        (pulse)
    );

    rpwc_frame_builder u_frame (
        .aclk    (aclk),
        .aresetn (aresetn),
        .pulse   (pulse),
        .cfg     (cfg),
        .evt     (frame)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        line_next     = line_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            line_next     = s_tdata[0];
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        code_next      = code_reg;
        if (step && frame.emit) begin
            out_valid_next = 1'b1;
            code_next      = frame.code;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        line_reg <= line_next;
        code_reg <= code_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = code_reg;

endmodule
